### rtl/v2u_pkg.sv
// Shared types, constants and UTF-8 byte formatting for the varint transcoder.
`default_nettype none

package v2u_pkg;

  localparam int unsigned CpW = 21;

  // Encoded length of a character, stored as byte count minus one.
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  localparam logic [CpW-1:0] LIM_1 = 21'h00007F;
  localparam logic [CpW-1:0] LIM_2 = 21'h0007FF;
  localparam logic [CpW-1:0] LIM_3 = 21'h00FFFF;

  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT   = 8'h80;

  localparam logic [2:0] GRP_MAX = 3'd7;
  localparam logic [2:0] GRP_TOP = 3'd3;

  // One decoded character handed from the front to the back.
  typedef struct packed {
    logic           err;
    logic [CpW-1:0] cp;
  } v2u_char_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } v2u_qstat_t;

  function automatic logic [1:0] enc_len(input logic [CpW-1:0] cp);
    logic [1:0] len;
    if (cp <= LIM_1) len = LEN_1;
    else if (cp <= LIM_2) len = LEN_2;
    else if (cp <= LIM_3) len = LEN_3;
    else len = LEN_4;
    return len;
  endfunction

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    return CONT | {2'b00, bits};
  endfunction

  function automatic logic [7:0] enc_byte(input logic [CpW-1:0] cp,
                                          input logic [1:0]     len,
                                          input logic [1:0]     idx);
    logic [7:0] b;
    b = '0;
    case (len)
      LEN_1: b = {1'b0, cp[6:0]};
      LEN_2: begin
        case (idx)
          2'd0:    b = LEAD_2 | {3'b000, cp[10:6]};
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      LEN_3: begin
        case (idx)
          2'd0:    b = LEAD_3 | {4'h0, cp[15:12]};
          2'd1:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
          2'd1:    b = cont_byte(cp[17:12]);
          2'd2:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/v2u_front.sv
// Front end: gathers varint groups and hands complete characters to the queue.
`default_nettype none

module v2u_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  end_of_input_i,
  input  wire v2u_pkg::v2u_qstat_t   qstat_i,
  output logic                       push_o,
  output v2u_pkg::v2u_char_t         push_data_o
);

  logic [v2u_pkg::CpW-1:0] acc_q, acc_d;
  logic [2:0]              grp_q, grp_d;
  logic                    ovf_q, ovf_d;
  logic                    accept;
  logic [6:0]              bits;
  logic [v2u_pkg::CpW-1:0] acc_new;
  logic                    ovf_new;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign bits       = data_byte_i[6:0];

  always_comb begin
    acc_new = acc_q;
    case (grp_q)
      3'd0:    acc_new = acc_q | {14'd0, bits};
      3'd1:    acc_new = acc_q | {7'd0, bits, 7'd0};
      3'd2:    acc_new = acc_q | {bits, 14'd0};
      default: acc_new = acc_q;
    endcase
    // fourth group has no room above bit 20; any later group overflows
    ovf_new = ovf_q || (grp_q == v2u_pkg::GRP_TOP && bits != 7'd0) ||
              (grp_q > v2u_pkg::GRP_TOP);
  end

  always_comb begin
    acc_d       = acc_q;
    grp_d       = grp_q;
    ovf_d       = ovf_q;
    push_o      = 1'b0;
    push_data_o = '{err: 1'b1, cp: '0};
    if (accept) begin
      if (end_of_input_i) begin
        push_o = (grp_q != 3'd0);
        acc_d  = '0;
        grp_d  = '0;
        ovf_d  = 1'b0;
      end else if (data_byte_i[7]) begin
        acc_d = acc_new;
        ovf_d = ovf_new;
        grp_d = (grp_q == v2u_pkg::GRP_MAX) ? grp_q : grp_q + 3'd1;
      end else begin
        push_o      = 1'b1;
        push_data_o = '{err: ovf_new, cp: acc_new};
        acc_d       = '0;
        grp_d       = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      grp_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      grp_q <= grp_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### rtl/v2u_queue.sv
// Two-entry character queue between the front and back ends.
`default_nettype none

module v2u_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire v2u_pkg::v2u_char_t  push_data_i,
  input  wire logic                pop_i,
  output v2u_pkg::v2u_char_t       pop_data_o,
  output v2u_pkg::v2u_qstat_t      qstat_o
);

  v2u_pkg::v2u_char_t mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign pop_data_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/v2u_back.sv
// Back end: serializes each queued character into UTF-8 bytes on a registered output.
`default_nettype none

module v2u_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire v2u_pkg::v2u_char_t  q_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               utf8_byte_o,
  output logic                     last_of_char_o,
  output logic                     error_o
);

  logic                    busy_q, busy_d;
  logic [v2u_pkg::CpW-1:0] cp_q, cp_d;
  logic                    err_q, err_d;
  logic [1:0]              len_q, len_d;
  logic [1:0]              idx_q, idx_d;
  logic                    ovld_q, ovld_d;
  logic [7:0]              obyte_q, obyte_d;
  logic                    olast_q, olast_d;
  logic                    oerr_q, oerr_d;
  logic                    out_free;
  logic                    emit;
  logic                    is_last;

  assign out_free = !ovld_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign is_last  = err_q || (idx_q == len_q);
  // next character loads as soon as the current one issues its final byte
  assign pop_o    = !q_empty_i && (!busy_q || (emit && is_last));

  always_comb begin
    busy_d  = busy_q;
    cp_d    = cp_q;
    err_d   = err_q;
    len_d   = len_q;
    idx_d   = idx_q;
    ovld_d  = ovld_q && out_stall_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    if (emit) begin
      ovld_d  = 1'b1;
      obyte_d = err_q ? 8'h00 : v2u_pkg::enc_byte(cp_q, len_q, idx_q);
      olast_d = is_last;
      oerr_d  = err_q;
      idx_d   = idx_q + 2'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      cp_d   = q_data_i.cp;
      err_d  = q_data_i.err;
      len_d  = v2u_pkg::enc_len(q_data_i.cp);
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q    <= cp_d;
    err_q   <= err_d;
    len_q   <= len_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  assign out_valid_o    = ovld_q;
  assign utf8_byte_o    = obyte_q;
  assign last_of_char_o = olast_q;
  assign error_o        = oerr_q;

endmodule

`default_nettype wire

### rtl/varint_to_utf8_transcoder.sv
// Top level of the varint to UTF-8 transcoder.
// Takes one varint byte per cycle while in_stall_o is low and emits each
// completed character as 1 to 4 UTF-8 bytes, one byte per cycle on a
// registered output while out_stall_i is low; a malformed or truncated
// varint gives a single result with error set. Input requests are taken
// every cycle while the two-entry character queue has room; output
// throughput is one byte per cycle unless stalled, bounded by the single-byte
// output port. A final varint byte passes through the character queue and
// the back end's character registers before its first UTF-8 byte is registered.
`default_nettype none

module varint_to_utf8_transcoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      utf8_byte_o,
  output logic            last_of_char_o,
  output logic            error_o
);

  v2u_pkg::v2u_qstat_t qstat;
  v2u_pkg::v2u_char_t  push_data;
  v2u_pkg::v2u_char_t  pop_data;
  logic                push;
  logic                pop;

  v2u_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  v2u_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  v2u_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (qstat.empty),
    .q_data_i       (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .utf8_byte_o    (utf8_byte_o),
    .last_of_char_o (last_of_char_o),
    .error_o        (error_o)
  );

endmodule

`default_nettype wire

### rtl/v2u_checker.sv
// Port-level checks for the varint to UTF-8 transcoder, bound to the top level.
`default_nettype none

module v2u_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] data_byte_i,
  input wire logic       end_of_input_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] utf8_byte_o,
  input wire logic       last_of_char_o,
  input wire logic       error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(utf8_byte_o) &&
      $stable(last_of_char_o) && $stable(error_o))
    else $error("stalled result changed");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_of_char_o && utf8_byte_o == 8'h00)
    else $error("error result malformed");

  a_lead_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_char_o |-> utf8_byte_o[7] && !error_o)
    else $error("non-final byte is not part of a multi-byte sequence");

  a_tail_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_char_o
      |=> !out_valid_o || utf8_byte_o[7:6] == 2'b10)
    else $error("byte after a lead or middle byte is not a continuation");

endmodule

bind varint_to_utf8_transcoder v2u_checker u_v2u_checker (.*);

`default_nettype wire

### tb/varint_utf8_checker.sv
`timescale 1ns / 1ps
// Checker: watches both channels, predicts UTF-8 output bytes and compares them.
module varint_utf8_checker
  import v2u_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_input_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] utf8_byte_i,
  input  wire logic       last_of_char_i,
  input  wire logic       error_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o,
  output int              error_seen_o
);

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       err;
  } utf8_res_t;

  utf8_res_t      expected_bytes[$];
  logic [CpW-1:0] cp_acc;
  logic [2:0]     grp_seen;
  logic           ovf_pend;
  int             mismatches = 0;
  int             exp_count  = 0;
  int             checked    = 0;
  int             error_seen = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = exp_count;
  assign checked_o    = checked;
  assign error_seen_o = error_seen;

  task automatic push_res(input logic [7:0] o, input logic l, input logic e);
    expected_bytes.push_back({o, l, e});
  endtask

  task automatic clear_varint();
    cp_acc   = '0;
    grp_seen = '0;
    ovf_pend = 1'b0;
  endtask

  // Gathers 7-bit groups; emits the UTF-8 bytes once a terminating byte arrives.
  task automatic predict_request(input logic [7:0] d, input logic eoi);
    logic [6:0] bits;
    bits = d[6:0];
    if (eoi) begin
      // truncated varint gives one error result, idle end of stream gives none
      if (grp_seen != 3'd0) push_res(8'h00, 1'b1, 1'b1);
      clear_varint();
      return;
    end
    case (grp_seen)
      3'd0:    cp_acc[6:0]   = cp_acc[6:0] | bits;
      3'd1:    cp_acc[13:7]  = cp_acc[13:7] | bits;
      3'd2:    cp_acc[20:14] = cp_acc[20:14] | bits;
      GRP_TOP: if (bits != 7'd0) ovf_pend = 1'b1;
      default: ovf_pend = 1'b1;
    endcase
    if (grp_seen != GRP_MAX) grp_seen = grp_seen + 3'd1;
    if (d[7]) return;
    if (ovf_pend) begin
      push_res(8'h00, 1'b1, 1'b1);
    end else if (cp_acc <= LIM_1) begin
      push_res({1'b0, cp_acc[6:0]}, 1'b1, 1'b0);
    end else if (cp_acc <= LIM_2) begin
      push_res(LEAD_2 | {3'b000, cp_acc[10:6]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[5:0]}, 1'b1, 1'b0);
    end else if (cp_acc <= LIM_3) begin
      push_res(LEAD_3 | {4'h0, cp_acc[15:12]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[11:6]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[5:0]}, 1'b1, 1'b0);
    end else begin
      push_res(LEAD_4 | {5'b00000, cp_acc[20:18]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[17:12]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[11:6]}, 1'b0, 1'b0);
      push_res(CONT | {2'b00, cp_acc[5:0]}, 1'b1, 1'b0);
    end
    clear_varint();
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    utf8_res_t want;
    checked++;
    if (error_i) error_seen++;
    if (expected_bytes.size() == 0) begin
      note_mismatch("unexpected result, utf8_byte", 0, utf8_byte_i);
      return;
    end
    want = expected_bytes.pop_front();
    if (utf8_byte_i !== want.octet) note_mismatch("utf8_byte", want.octet, utf8_byte_i);
    if (last_of_char_i !== want.last) note_mismatch("last_of_char", want.last, last_of_char_i);
    if (error_i !== want.err) note_mismatch("error", want.err, error_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_varint();
      expected_bytes.delete();
      exp_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_request(data_byte_i, end_of_input_i);
      if (out_valid_i && !out_stall_i) check_result();
      exp_count = expected_bytes.size();
    end
  end

endmodule

### tb/varint_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives varint streams into the transcoder and gives the verdict.
module varint_to_utf8_transcoder_tb;
  import v2u_pkg::*;

  typedef enum logic [2:0] {
    SEQ_CHAR,
    SEQ_OVERFLOW,
    SEQ_TRUNCATED,
    SEQ_END,
    SEQ_NOISE
  } seq_kind_e;

  localparam int HoldCycles  = 300;
  localparam int PhaseBudget = 120;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] data_byte    = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_stall    = 1'b0;
  wire logic       in_stall;
  wire logic       out_valid;
  wire logic [7:0] utf8_byte;
  wire logic       last_of_char;
  wire logic       error;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int requests_sent  = 0;
  int fail_count, pending, checked, error_seen;

  always #5 clk = ~clk;

  varint_to_utf8_transcoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .utf8_byte_o    (utf8_byte),
    .last_of_char_o (last_of_char),
    .error_o        (error)
  );

  varint_utf8_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_input_i (end_of_input),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .utf8_byte_i    (utf8_byte),
    .last_of_char_i (last_of_char),
    .error_i        (error),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .error_seen_o   (error_seen)
  );

  // Output side: random stall, or a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(input logic [7:0] d, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Minimal LEB128 encoding, plus pad trailing zero groups.
  task automatic send_code(input logic [CpW-1:0] cp, input int pad);
    int n;
    int total;
    logic [CpW-1:0] rest;
    n     = (cp < 21'h80) ? 1 : (cp < 21'h4000) ? 2 : 3;
    total = n + pad;
    rest  = cp;
    for (int i = 0; i < total; i++) begin
      send_request({(i < total - 1), rest[6:0]}, 1'b0);
      rest = rest >> 7;
    end
  endtask

  // Four to nine groups; a four-group varint gets a nonzero top group.
  task automatic send_overflow();
    int len;
    logic [6:0] bits;
    len = $urandom_range(4, 9);
    for (int i = 0; i < len; i++) begin
      bits = 7'($urandom_range(127));
      if (i == 3 && len == 4 && bits == 7'd0) bits = 7'd1;
      send_request({(i < len - 1), bits}, 1'b0);
    end
  endtask

  task automatic send_truncated();
    int k;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) send_request({1'b1, 7'($urandom_range(127))}, 1'b0);
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_char();
    logic [CpW-1:0] lo, hi, cp;
    int n, pad;
    case ($urandom_range(3))
      0:       begin lo = 21'h0;     hi = LIM_1;       end
      1:       begin lo = 21'h80;    hi = LIM_2;       end
      2:       begin lo = 21'h800;   hi = LIM_3;       end
      default: begin lo = 21'h10000; hi = 21'h1FFFFF;  end
    endcase
    case ($urandom_range(7))
      0:       cp = lo;
      1:       cp = hi;
      default: cp = lo + CpW'($urandom_range(hi - lo));
    endcase
    n   = (cp < 21'h80) ? 1 : (cp < 21'h4000) ? 2 : 3;
    pad = ($urandom_range(4) == 0) ? $urandom_range(4 - n) : 0;
    send_code(cp, pad);
  endtask

  task automatic send_random_seq();
    seq_kind_e kind;
    int r;
    r = $urandom_range(99);
    kind = (r < 65) ? SEQ_CHAR : (r < 75) ? SEQ_OVERFLOW : (r < 85) ? SEQ_TRUNCATED :
           (r < 90) ? SEQ_END : SEQ_NOISE;
    case (kind)
      SEQ_CHAR:      send_random_char();
      SEQ_OVERFLOW:  send_overflow();
      SEQ_TRUNCATED: send_truncated();
      SEQ_END:       send_request(8'($urandom_range(255)), 1'b1);
      default:       send_request(8'($urandom_range(255)), 1'b0);
    endcase
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int idle_mix[4];
    int stall_mix[4];
    int target;
    idle_mix  = '{0, 86, 0, 12};
    stall_mix = '{0, 0, 86, 12};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length thresholds, extremes, non-minimal, overflow, end cases
    send_code(21'h0, 1);
    send_code(LIM_1, 0);
    send_code(21'h80, 0);
    send_code(LIM_2, 0);
    send_code(21'h800, 0);
    send_code(LIM_3, 0);
    send_code(21'h10000, 0);
    send_code(21'h1FFFFF, 0);
    send_request(8'h80, 1'b0);     // top group nonzero
    send_request(8'h80, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h80, 1'b0);     // fifth group
    send_request(8'h80, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'hFF, 1'b1);     // end of stream while idle
    send_request(8'hFF, 1'b0);     // end of stream mid varint
    send_request(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      target = requests_sent + PhaseBudget;
      if (p == 0) hold_req = ~hold_req;  // back-pressure fills the queue
      while (requests_sent < target) send_random_seq();
      drain();
    end

    $display("Run covered %0d input requests across four idle/stall mixes",
             requests_sent);
    $display("and a %0d-cycle hold-off; %0d output bytes checked, %0d of them errors.",
             HoldCycles, checked, error_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
